// ===== hdl/slcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

  // Defaults and fixed field widths.
  localparam int MAX_DELIM_DEF = 16;
  localparam int LINE_W        = 24;
  localparam int CFG_W         = 24;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Configuration register indexes.
  localparam logic REG_SYNTAX = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // Syntax modes.
  typedef enum logic [1:0] {
    SYN_C    = 2'd0,
    SYN_HASH = 2'd1,
    SYN_PY   = 2'd2,
    SYN_LUA  = 2'd3
  } syntax_t;

  // Lexer states.
  typedef enum logic [2:0] {
    LX_CODE   = 3'd0,
    LX_LINE   = 3'd1,
    LX_BLOCK  = 3'd2,
    LX_STR    = 3'd3,
    LX_RAW    = 3'd4,
    LX_TRIPLE = 3'd5,
    LX_LONG   = 3'd6,
    LX_DELIM  = 3'd7
  } lex_mode_t;

  // One byte to examine together with its lookahead.
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] la0;
    logic [7:0] la1;
    logic [7:0] la2;
    logic [1:0] avail;
  } step_t;

  // Step control from the window to the lexer.
  typedef struct packed {
    logic fire;
    logic finish;
  } step_ctl_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_LB    = 8'h5B;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_RB    = 8'h5D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LC    = 8'h7B;
  localparam logic [7:0] CH_RC    = 8'h7D;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CH_US;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/slcd_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slcd_window (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire logic           push_last,
  input  wire logic [7:0]     push_ch,
  input  wire logic           out_free,
  output slcd_pkg::step_t     step,
  output slcd_pkg::step_ctl_t ctl,
  output logic                busy
);
  import slcd_pkg::*;

  logic [7:0] buf_r [4];
  logic [7:0] buf_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic       drain_r, drain_nxt;
  logic       pop, finish;
  logic [2:0] wr_pos;

  // The head is examined once three bytes follow it, or while draining.
  assign finish = drain_r && cnt_r == 3'd1 && out_free;
  assign pop    = cnt_r == 3'd4 || (drain_r && cnt_r > 3'd1) || finish;
  assign busy   = drain_r;

  assign step.c     = buf_r[0];
  assign step.la0   = buf_r[1];
  assign step.la1   = buf_r[2];
  assign step.la2   = buf_r[3];
  assign step.avail = 2'(cnt_r - 3'd1);
  assign ctl.fire   = pop;
  assign ctl.finish = finish;

  // Shift out the head, append the new beat; empty slots read as zero.
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      buf_nxt[2] = buf_r[3];
      buf_nxt[3] = 8'h00;
      cnt_nxt    = cnt_r - 3'd1;
    end
    wr_pos = cnt_nxt;
    if (push) begin
      buf_nxt[wr_pos[1:0]] = push_ch;
      cnt_nxt = cnt_nxt + 3'd1;
    end
    drain_nxt = drain_r;
    if (push && push_last) begin
      drain_nxt = 1'b1;
    end else if (finish) begin
      drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      drain_r <= 1'b0;
      for (int i = 0; i < 4; i++) buf_r[i] <= 8'h00;
    end else begin
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
      buf_r   <= buf_nxt;
    end
  end

  // Checks on the window bookkeeping.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("window count out of range");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> cnt_r != 3'd0)
    else $error("draining with an empty window");
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> cnt_r == 3'd0 && !drain_r)
    else $error("window not empty after finish");

endmodule

`default_nettype wire

// ===== hdl/slcd_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slcd_lexer #(
  parameter int MAX_DELIM = slcd_pkg::MAX_DELIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [1:0]                  syntax_mode,
  input  wire logic [slcd_pkg::LINE_W-1:0] target_line,
  input  wire slcd_pkg::step_t             step,
  input  wire slcd_pkg::step_ctl_t         ctl,
  output logic                             found_nxt
);
  import slcd_pkg::*;

  localparam int DW = $clog2(MAX_DELIM + 4);
  localparam int AW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam logic [DW-1:0] DMAX = DW'(MAX_DELIM);

  lex_mode_t         mode_r, mode_nxt, mode_e;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              found_r;
  logic [7:0]        oq_r, oq_nxt;
  logic [7:0]        dc_r [MAX_DELIM];
  logic [DW-1:0]     dl_r, dl_nxt, tp_r, tp_nxt, tp_m1;
  logic [7:0]        rc_r [3];
  logic [7:0]        rc_nxt [3];
  logic [2:0]        run_r, run_nxt;
  logic [1:0]        skip_r, skip_nxt;
  logic              dc_we;
  logic [7:0]        c, n, tch;
  logic              q, stop, glue, raw_pre;
  logic [DW:0]       tp_inc;

  assign c     = step.c;
  assign n     = (step.avail >= 2'd1) ? step.la0 : 8'h00;
  assign q     = c == CH_DQ || c == CH_SQ;
  assign tp_m1 = tp_r - DW'(1);

  // Next byte of the raw string terminator.
  always_comb begin
    if (tp_r == '0) begin
      tch = CH_RP;
    end else if (tp_r <= dl_r && tp_m1 < DMAX) begin
      tch = dc_r[tp_m1[AW-1:0]];
    end else begin
      tch = CH_DQ;
    end
  end

  // Raw string prefix: R, LR, uR, UR or u8R right before the quote.
  always_comb begin
    raw_pre = 1'b0;
    if (rc_r[0] == CH_R) begin
      case (run_r)
        3'd1:    raw_pre = 1'b1;
        3'd2:    raw_pre = rc_r[1] == CH_L || rc_r[1] == CH_LU || rc_r[1] == CH_U;
        3'd3:    raw_pre = rc_r[1] == CH_8 && rc_r[2] == CH_LU;
        default: raw_pre = 1'b0;
      endcase
    end
  end

  // Bytes that do not count as code.
  always_comb begin
    glue = is_ws(c) || c == CH_COMMA || c == CH_SEMI || c == CH_LP || c == CH_RP ||
           c == CH_LC || c == CH_RC || c == CH_LB || c == CH_RB || c == CH_DQ ||
           c == CH_SQ || c == CH_BS;
    if ((syntax_mode == SYN_HASH || syntax_mode == SYN_PY) && c == CH_HASH) glue = 1'b1;
    if (syntax_mode == SYN_LUA && c == CH_DASH) glue = 1'b1;
    if (syntax_mode == SYN_C && c == CH_SLASH && (n == CH_SLASH || n == CH_STAR)) begin
      glue = 1'b1;
    end
  end

  // One lexer step for the head byte.
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    found_nxt = found_r;
    oq_nxt    = oq_r;
    dl_nxt    = dl_r;
    tp_nxt    = tp_r;
    skip_nxt  = skip_r;
    dc_we     = 1'b0;
    stop      = 1'b0;
    mode_e    = mode_r;
    tp_inc    = {1'b0, tp_r} + (DW+1)'(1);
    rc_nxt    = rc_r;
    run_nxt   = run_r;
    if (ctl.fire) begin
      rc_nxt[2] = rc_r[1];
      rc_nxt[1] = rc_r[0];
      rc_nxt[0] = c;
      run_nxt   = is_ident(c) ? ((run_r < 3'd7) ? run_r + 3'd1 : 3'd7) : 3'd0;
      if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
        if (c == CH_NL && line_r != LINE_MAX) line_nxt = line_r + LINE_W'(1);
      end else begin
        // Raw string delimiter collection.
        if (mode_r == LX_DELIM) begin
          if (dl_r <= DMAX && c == CH_LP) begin
            mode_nxt = LX_RAW;
            tp_nxt   = '0;
            stop     = 1'b1;
          end else if (dl_r <= DMAX && c != CH_RP && c != CH_BS && c != CH_DQ &&
                       !is_ws(c)) begin
            dc_we  = dl_r < DMAX;
            dl_nxt = dl_r + DW'(1);
            stop   = 1'b1;
          end else begin
            mode_e = LX_STR;
            oq_nxt = CH_DQ;
          end
        end
        if (!stop) begin
          mode_nxt = mode_e;
          if (target_line != '0 && line_r == target_line && mode_e == LX_CODE && !glue) begin
            found_nxt = 1'b1;
          end
          if (c == CH_NL) begin
            if (mode_e == LX_LINE) mode_nxt = LX_CODE;
            if (mode_e == LX_RAW) tp_nxt = '0;
            if (line_r != LINE_MAX) line_nxt = line_r + LINE_W'(1);
          end else begin
            case (mode_e)
              LX_CODE: begin
                if (syntax_mode == SYN_HASH || syntax_mode == SYN_PY) begin
                  if (c == CH_HASH) begin
                    mode_nxt = LX_LINE;
                  end else if (syntax_mode == SYN_PY && q && step.avail >= 2'd2 &&
                               step.la0 == c && step.la1 == c) begin
                    oq_nxt   = c;
                    mode_nxt = LX_TRIPLE;
                    skip_nxt = 2'd2;
                  end else if (q) begin
                    oq_nxt   = c;
                    mode_nxt = LX_STR;
                  end
                end else if (syntax_mode == SYN_LUA) begin
                  if (c == CH_DASH && n == CH_DASH) begin
                    if (step.avail == 2'd3 && step.la1 == CH_LB && step.la2 == CH_LB) begin
                      mode_nxt = LX_LONG;
                      skip_nxt = 2'd3;
                    end else begin
                      mode_nxt = LX_LINE;
                      skip_nxt = 2'd1;
                    end
                  end else if (c == CH_LB && n == CH_LB) begin
                    mode_nxt = LX_LONG;
                    skip_nxt = 2'd1;
                  end else if (q) begin
                    oq_nxt   = c;
                    mode_nxt = LX_STR;
                  end
                end else begin
                  if (c == CH_SLASH && n == CH_SLASH) begin
                    mode_nxt = LX_LINE;
                    skip_nxt = 2'd1;
                  end else if (c == CH_SLASH && n == CH_STAR) begin
                    mode_nxt = LX_BLOCK;
                    skip_nxt = 2'd1;
                  end else if (c == CH_DQ && raw_pre) begin
                    mode_nxt = LX_DELIM;
                    dl_nxt   = '0;
                  end else if (q) begin
                    oq_nxt   = c;
                    mode_nxt = LX_STR;
                  end
                end
              end
              LX_BLOCK: begin
                if (c == CH_STAR && n == CH_SLASH) begin
                  mode_nxt = LX_CODE;
                  skip_nxt = 2'd1;
                end
              end
              LX_STR: begin
                if (c == CH_BS) begin
                  skip_nxt = 2'd1;
                end else if (c == oq_r) begin
                  mode_nxt = LX_CODE;
                end
              end
              LX_RAW: begin
                if (c == tch) begin
                  tp_nxt = tp_inc[DW-1:0];
                  if (tp_inc >= {1'b0, dl_r} + (DW+1)'(2)) begin
                    mode_nxt = LX_CODE;
                    tp_nxt   = '0;
                  end
                end else begin
                  tp_nxt = (c == CH_RP) ? DW'(1) : '0;
                end
              end
              LX_TRIPLE: begin
                if (c == oq_r && step.avail >= 2'd2 && step.la0 == oq_r &&
                    step.la1 == oq_r) begin
                  mode_nxt = LX_CODE;
                  skip_nxt = 2'd2;
                end
              end
              LX_LONG: begin
                if (c == CH_RB && n == CH_RB) begin
                  mode_nxt = LX_CODE;
                  skip_nxt = 2'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // Lexer state; a finished text returns it to the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.finish) begin
      mode_r  <= LX_CODE;
      line_r  <= LINE_W'(1);
      found_r <= 1'b0;
      oq_r    <= 8'h00;
      dl_r    <= '0;
      tp_r    <= '0;
      run_r   <= 3'd0;
      skip_r  <= 2'd0;
      for (int i = 0; i < 3; i++) rc_r[i] <= 8'h00;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      found_r <= found_nxt;
      oq_r    <= oq_nxt;
      dl_r    <= dl_nxt;
      tp_r    <= tp_nxt;
      run_r   <= run_nxt;
      skip_r  <= skip_nxt;
      rc_r    <= rc_nxt;
    end
  end

  // Delimiter store; entries are only read after they are written.
  always_ff @(posedge clk) begin
    if (dc_we) dc_r[dl_r[AW-1:0]] <= c;
  end

  // Lexer consistency checks.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n) line_r != '0)
    else $error("line number reached zero");
  a_raw_len: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == LX_RAW |-> dl_r <= DMAX)
    else $error("raw string with oversized delimiter");
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && !ctl.finish |=> found_r)
    else $error("code flag dropped within a text");

endmodule

`default_nettype wire

// ===== hdl/source_line_code_detector.sv =====
// Source line code detector.
// Input channel: one source byte per beat (in_ch) with in_last on the final
// byte of a text. Result channel: one beat per text carrying out_has_code,
// which is 1 when the target line holds code outside comments and strings,
// or when target_line is 0. Configuration: cfg_wr_en writes cfg_wdata to
// register cfg_index (0 syntax mode, 1 target line). Write only while the
// block is idle; the block does not enforce this. Throughput: one byte per
// cycle unless stalled. Each byte is examined three bytes after it arrives,
// by a single-step lexer fed from a four-entry window. After the last byte
// in_stall is high while the window drains one byte per cycle; the final
// examination loads the result register. The next text can start right
// away. A held result (out_stall high) only delays that final examination;
// the input side keeps stalling until the result register is free.
// Reset (rst_n low at a clock edge) clears the lexer, the window, the result
// valid and the registers (C-style syntax, target line 0).
`timescale 1ns / 1ps
`default_nettype none

module source_line_code_detector #(
  parameter int MAX_DELIM = slcd_pkg::MAX_DELIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_ch,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_has_code,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [slcd_pkg::CFG_W-1:0] cfg_wdata
);
  import slcd_pkg::*;

  logic [1:0]        syntax_r;
  logic [LINE_W-1:0] target_r;
  logic              out_valid_r, has_code_r;
  logic              out_free, busy, found_nxt;
  step_t             step;
  step_ctl_t         ctl;

  assign out_free     = !out_valid_r || !out_stall;
  assign in_stall     = busy;
  assign out_valid    = out_valid_r;
  assign out_has_code = has_code_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syntax_r <= SYN_C;
      target_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYNTAX: syntax_r <= cfg_wdata[1:0];
        REG_TARGET: target_r <= cfg_wdata[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  slcd_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !busy),
    .push_last(in_last),
    .push_ch  (in_ch),
    .out_free (out_free),
    .step     (step),
    .ctl      (ctl),
    .busy     (busy)
  );

  slcd_lexer #(.MAX_DELIM(MAX_DELIM)) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .syntax_mode(syntax_r),
    .target_line(target_r),
    .step       (step),
    .ctl        (ctl),
    .found_nxt  (found_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) has_code_r <= target_r == '0 || found_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/sv/source_line_code_detector_test.sv =====
`timescale 1ns / 1ps

module source_line_code_detector_test;
  import slcd_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_ch = 8'h00;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_has_code;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  source_line_code_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_has_code(out_has_code),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t       pending_beats[$];
  logic        expected_flags[$];
  logic [7:0]  text_buf[$];
  int          errors = 0;
  bit          quiet = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  int          idle_cycles = 0;
  int          bytes_queued = 0;
  beat_t       cur_beat;

  // Shadow copy of the configuration and the lexer state.
  syntax_t     syn = SYN_C;
  logic [23:0] target = '0;
  lex_mode_t   lx;
  logic [23:0] line_no;
  logic        found;
  logic [7:0]  quote_ch;
  logic [7:0]  delim[16];
  int          delim_len;
  int          term_pos;
  logic [7:0]  win[4];
  int          win_cnt;
  logic [7:0]  recent[3];
  int          word_run;
  int          skip_left;

  function automatic bit space_char(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CH_US;
  endfunction

  task automatic clear_lexer();
    lx = LX_CODE; line_no = 24'd1; found = 0; quote_ch = 8'h00;
    for (int i = 0; i < 16; i++) delim[i] = 8'h00;
    delim_len = 0; term_pos = 0; win_cnt = 0; word_run = 0; skip_left = 0;
    for (int i = 0; i < 4; i++) win[i] = 8'h00;
    for (int i = 0; i < 3; i++) recent[i] = 8'h00;
  endtask

  task automatic shift_history(logic [7:0] c);
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = c;
    if (word_char(c)) word_run = (word_run < 7) ? word_run + 1 : 7;
    else word_run = 0;
  endtask

  task automatic next_line();
    if (line_no != LINE_MAX) line_no++;
  endtask

  function automatic bit raw_opener();
    if (recent[0] != CH_R) return 0;
    if (word_run == 1) return 1;
    if (word_run == 2) return recent[1] == CH_L || recent[1] == CH_LU || recent[1] == CH_U;
    if (word_run == 3) return recent[1] == CH_8 && recent[2] == CH_LU;
    return 0;
  endfunction

  function automatic logic [7:0] closer_char(int p);
    if (p == 0) return CH_RP;
    if (p <= delim_len && p - 1 < 16) return delim[p-1];
    return CH_DQ;
  endfunction

  function automatic bit not_code(logic [7:0] c, logic [7:0] n);
    if (space_char(c)) return 1;
    if (c == CH_COMMA || c == CH_SEMI || c == CH_LP || c == CH_RP || c == CH_LC ||
        c == CH_RC || c == CH_LB || c == CH_RB || c == CH_DQ || c == CH_SQ ||
        c == CH_BS) return 1;
    if ((syn == SYN_HASH || syn == SYN_PY) && c == CH_HASH) return 1;
    if (syn == SYN_LUA && c == CH_DASH) return 1;
    if (syn == SYN_C && c == CH_SLASH && (n == CH_SLASH || n == CH_STAR)) return 1;
    return 0;
  endfunction

  // Lex one byte with up to three bytes of lookahead.
  task automatic lex_byte(logic [7:0] c, logic [7:0] a0, logic [7:0] a1,
                          logic [7:0] a2, int avail);
    logic [7:0] n;
    bit         q;
    n = (avail >= 1) ? a0 : 8'h00;
    q = (c == CH_DQ || c == CH_SQ);
    if (skip_left > 0) begin
      skip_left--;
      if (c == CH_NL) next_line();
      shift_history(c);
      return;
    end
    if (lx == LX_DELIM) begin
      if (delim_len <= 16 && c == CH_LP) begin
        lx = LX_RAW; term_pos = 0; shift_history(c);
        return;
      end
      if (delim_len <= 16 && c != CH_RP && c != CH_BS && c != CH_DQ && !space_char(c)) begin
        if (delim_len < 16) delim[delim_len] = c;
        delim_len++;
        shift_history(c);
        return;
      end
      lx = LX_STR; quote_ch = CH_DQ;
    end
    if (target != 0 && line_no == target && lx == LX_CODE && !not_code(c, n)) found = 1;
    if (c == CH_NL) begin
      if (lx == LX_LINE) lx = LX_CODE;
      if (lx == LX_RAW) term_pos = 0;
      next_line();
      shift_history(c);
      return;
    end
    case (lx)
      LX_CODE: begin
        if (syn == SYN_HASH || syn == SYN_PY) begin
          if (c == CH_HASH) lx = LX_LINE;
          else if (syn == SYN_PY && q && avail >= 2 && a0 == c && a1 == c) begin
            quote_ch = c; lx = LX_TRIPLE; skip_left = 2;
          end else if (q) begin
            quote_ch = c; lx = LX_STR;
          end
        end else if (syn == SYN_LUA) begin
          if (c == CH_DASH && n == CH_DASH) begin
            if (avail >= 3 && a1 == CH_LB && a2 == CH_LB) begin
              lx = LX_LONG; skip_left = 3;
            end else begin
              lx = LX_LINE; skip_left = 1;
            end
          end else if (c == CH_LB && n == CH_LB) begin
            lx = LX_LONG; skip_left = 1;
          end else if (q) begin
            quote_ch = c; lx = LX_STR;
          end
        end else begin
          if (c == CH_SLASH && n == CH_SLASH) begin
            lx = LX_LINE; skip_left = 1;
          end else if (c == CH_SLASH && n == CH_STAR) begin
            lx = LX_BLOCK; skip_left = 1;
          end else if (c == CH_DQ && raw_opener()) begin
            lx = LX_DELIM; delim_len = 0;
          end else if (q) begin
            quote_ch = c; lx = LX_STR;
          end
        end
      end
      LX_BLOCK: if (c == CH_STAR && n == CH_SLASH) begin
        lx = LX_CODE; skip_left = 1;
      end
      LX_STR: begin
        if (c == CH_BS) skip_left = 1;
        else if (c == quote_ch) lx = LX_CODE;
      end
      LX_RAW: begin
        if (c == closer_char(term_pos)) begin
          term_pos++;
          if (term_pos >= delim_len + 2) begin
            lx = LX_CODE; term_pos = 0;
          end
        end else begin
          term_pos = (c == CH_RP) ? 1 : 0;
        end
      end
      LX_TRIPLE: if (c == quote_ch && avail >= 2 && a0 == quote_ch && a1 == quote_ch) begin
        lx = LX_CODE; skip_left = 2;
      end
      LX_LONG: if (c == CH_RB && n == CH_RB) begin
        lx = LX_CODE; skip_left = 1;
      end
      default: ;
    endcase
    shift_history(c);
  endtask

  task automatic pop_window(int avail);
    lex_byte(win[0], win[1], win[2], win[3], avail);
    win[0] = win[1]; win[1] = win[2]; win[2] = win[3]; win[3] = 8'h00;
    win_cnt--;
  endtask

  // Advance the shadow lexer by one accepted beat.
  task automatic predict_beat(logic [7:0] c, logic last);
    if (win_cnt > 3) win_cnt = 3;
    win[win_cnt] = c;
    win_cnt++;
    if (win_cnt == 4) pop_window(3);
    if (last) begin
      while (win_cnt > 0) pop_window(win_cnt - 1);
      expected_flags.push_back(target == 0 || found);
      clear_lexer();
    end
  endtask

  // Input side driver with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_ch <= cur_beat.ch;
        in_last <= cur_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall bursts.
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on accepted input beats, check result beats.
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        predict_beat(in_ch, in_last);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (expected_flags.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0b", $time, out_has_code);
          errors++;
        end else if (expected_flags[0] !== out_has_code) begin
          $display("%0t has_code mismatch: expected %0b actual %0b", $time,
                   expected_flags[0], out_has_code);
          errors++;
          void'(expected_flags.pop_front());
        end else begin
          void'(expected_flags.pop_front());
        end
      end
      if (idle_cycles >= 2000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_SYNTAX) syn = syntax_t'(val[1:0]);
    else target = val[23:0];
  endtask

  task automatic configure(logic [CFG_W-1:0] s, logic [CFG_W-1:0] t);
    write_reg(REG_SYNTAX, s);
    write_reg(REG_TARGET, t);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_flags.size() != 0 || in_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Move the built text to the driver queue, last flag on its final byte.
  task automatic send_text();
    beat_t b;
    if (text_buf.size() == 0) text_buf.push_back(8'h61);
    for (int i = 0; i < text_buf.size(); i++) begin
      b.ch = text_buf[i];
      b.last = (i == text_buf.size() - 1);
      pending_beats.push_back(b);
    end
    bytes_queued += text_buf.size();
    text_buf.delete();
  endtask

  // Append one random token, mostly lexer syntax with random content.
  task automatic add_token();
    int k;
    k = $urandom_range(0, 27);
    case (k)
      0: add_str("//");
      1: add_str("/*");
      2: add_str("*/");
      3: add_str("\"");
      4: add_str("'");
      5: add_str("\\");
      6: add_str("R\"");
      7: add_str("u8R\"");
      8: add_str("LR\"");
      9: add_str("uR\"");
      10: add_str("UR\"");
      11: add_str("(");
      12: add_str(")");
      13: add_str("#");
      14: add_str("\"\"\"");
      15: add_str("'''");
      16: add_str("--");
      17: add_str("--[[");
      18: add_str("[[");
      19: add_str("]]");
      20, 21: add_str("\n");
      22: add_str(" ");
      23: begin
        // Raw string delimiter of random length, sometimes too long.
        int len;
        len = $urandom_range(0, 18);
        for (int i = 0; i < len; i++) text_buf.push_back(8'(8'h61 + $urandom_range(0, 3)));
      end
      24, 25: begin
        int len;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) text_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
      end
      default: text_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int ntexts;
    int len;
    clear_lexer();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: comments, block comment, raw string, Lua long bracket.
    configure(CFG_W'(SYN_C), 24'd1);
    add_str("a//b"); send_text();
    add_str("/*x*/;"); send_text();
    add_str("R\"d(z)d\""); send_text();
    wait_drained();
    configure(CFG_W'(SYN_LUA), 24'd0);
    add_str("--[[x]]"); send_text();
    wait_drained();

    // Random phases across all syntaxes, with target line 0, 1 to 4 or the maximum.
    while (bytes_queued < 850) begin
      if (bytes_queued > 720) quiet = 1;
      case ($urandom_range(0, 5))
        0: configure(CFG_W'($urandom_range(0, 3)), 24'd0);
        1: configure(CFG_W'($urandom_range(0, 3)), 24'hFFFFFF);
        default: configure(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(1, 4)));
      endcase
      ntexts = $urandom_range(3, 6);
      for (int t = 0; t < ntexts; t++) begin
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++) add_token();
        send_text();
      end
      wait_drained();
    end

    wait_drained();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== source_line_code_detector.f =====
hdl/slcd_pkg.sv
hdl/slcd_window.sv
hdl/slcd_lexer.sv
hdl/source_line_code_detector.sv
tb/sv/source_line_code_detector_test.sv
